// ===== hdl/ogi_pkg.sv =====
// Shared types and constants of the orbit gravity integrator.
// Used by the channel interfaces, the arithmetic unit and the top level.
// No dependencies.
package ogi_pkg;

    // Datapath widths of the shared arithmetic unit
    localparam int WIDE_W     = 128;
    localparam int MUL_W      = 64;
    localparam int DIGIT_W    = 16;
    localparam int MUL_DIGITS = MUL_W / DIGIT_W;
    localparam int CNT_W      = 7;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int DT_W        = 12;
    localparam int RADIUS_W    = 24;
    localparam int GRAV_W      = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_TIME_STEP       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PLANET_RADIUS   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SURFACE_GRAVITY = 2'd2;

    localparam logic [DT_W-1:0]     DT_RESET     = 12'd48;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd6378000;
    localparam logic [GRAV_W-1:0]   GRAV_RESET   = 24'd642689;

    // Operation codes of the arithmetic unit
    localparam logic [1:0] OP_MUL  = 2'd0;
    localparam logic [1:0] OP_DIV  = 2'd1;
    localparam logic [1:0] OP_SQRT = 2'd2;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic ovf;
    } alu_rsp_t;

endpackage

// ===== hdl/ogi_ifs.sv =====
// Valid/ready channel interfaces of the orbit gravity integrator.
// Depends on ogi_pkg for the configuration port widths.
interface ogi_in_if #(parameter int STATE_WIDTH = 40);
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic signed [STATE_WIDTH-1:0] load_pos_x;
    logic signed [STATE_WIDTH-1:0] load_pos_y;
    logic signed [STATE_WIDTH-1:0] load_vel_x;
    logic signed [STATE_WIDTH-1:0] load_vel_y;

    modport source (output valid, mode, load_pos_x, load_pos_y, load_vel_x, load_vel_y,
                    input ready);
    modport sink (input valid, mode, load_pos_x, load_pos_y, load_vel_x, load_vel_y,
                  output ready);
endinterface

interface ogi_out_if #(parameter int STATE_WIDTH = 40, parameter int ACCEL_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [STATE_WIDTH-1:0] new_pos_x;
    logic signed [STATE_WIDTH-1:0] new_pos_y;
    logic signed [STATE_WIDTH-1:0] new_vel_x;
    logic signed [STATE_WIDTH-1:0] new_vel_y;
    logic signed [ACCEL_WIDTH-1:0] accel_x;
    logic signed [ACCEL_WIDTH-1:0] accel_y;
    logic                          at_center;
    logic                          saturated;

    modport source (output valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y,
                    accel_x, accel_y, at_center, saturated, input ready);
    modport sink (input valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y,
                  accel_x, accel_y, at_center, saturated, output ready);
endinterface

interface ogi_cfg_if import ogi_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/ogi_alu.sv =====
// Shared multi-cycle arithmetic unit: multiply, divide and square root.
// Depends on ogi_pkg for operation codes and request/response structs.
module ogi_alu import ogi_pkg::*; #(
    parameter int STATE_WIDTH = 40,
    parameter int ACCEL_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  alu_req_t          req,
    input  logic [WIDE_W-1:0] opa,
    input  logic [WIDE_W-1:0] opb,
    output alu_rsp_t          rsp,
    output logic [WIDE_W-1:0] result
);

    localparam int TW     = WIDE_W + 2;
    localparam int DIV_SH = WIDE_W - ACCEL_WIDTH;
    localparam int SQ_SH  = WIDE_W - 2 * STATE_WIDTH;

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       op_reg, op_next;
    logic             ovf_reg, ovf_next;
    logic [WIDE_W-1:0] acc_reg, acc_next;
    logic [WIDE_W-1:0] sh_reg, sh_next;
    logic [WIDE_W-1:0] d_reg, d_next;
    logic [MUL_W-1:0]  q_reg, q_next;
    logic [MUL_W-1:0]  mula_reg, mula_next;

    logic [DIGIT_W-1:0]       digit;
    logic [MUL_W+DIGIT_W-1:0] mul_prod;
    logic [WIDE_W-1:0]        mul_sum;
    logic [TW-1:0]            t_val;
    logic [TW-1:0]            trial;
    logic [TW-1:0]            diff;
    logic                     ge;
    logic [WIDE_W-1:0]        rem_next;

    // One multiplier digit per cycle, most significant digit first.
    assign digit    = sh_reg[WIDE_W-1 -: DIGIT_W];
    assign mul_prod = mula_reg * digit;
    assign mul_sum  = (acc_reg << DIGIT_W) + WIDE_W'(mul_prod);

    // Shared compare and subtract for divide and square root steps.
    always_comb
    begin
        if (op_reg == OP_SQRT)
        begin
            t_val = {acc_reg, sh_reg[WIDE_W-1 -: 2]};
            trial = TW'({q_reg, 2'b01});
        end
        else
        begin
            t_val = {1'b0, acc_reg, sh_reg[WIDE_W-1]};
            trial = TW'(d_reg);
        end
    end

    assign ge       = (t_val >= trial);
    assign diff     = t_val - trial;
    assign rem_next = ge ? diff[WIDE_W-1:0] : t_val[WIDE_W-1:0];

    // Start loads the operands; each later cycle runs one step.
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        ovf_next  = ovf_reg;
        acc_next  = acc_reg;
        sh_next   = sh_reg;
        d_next    = d_reg;
        q_next    = q_reg;
        mula_next = mula_reg;
        if (busy_reg && cnt_reg == '0)
        begin
            busy_next = 1'b0;
        end
        if (req.start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            ovf_next  = 1'b0;
            q_next    = '0;
            d_next    = opb;
            case (req.op)
                OP_MUL:
                begin
                    mula_next = opa[MUL_W-1:0];
                    sh_next   = {opb[MUL_W-1:0], {(WIDE_W-MUL_W){1'b0}}};
                    acc_next  = '0;
                    cnt_next  = CNT_W'(MUL_DIGITS);
                end
                OP_DIV:
                begin
                    acc_next = opa >> ACCEL_WIDTH;
                    sh_next  = opa << DIV_SH;
                    ovf_next = ((opa >> ACCEL_WIDTH) >= opb);
                    cnt_next = CNT_W'(ACCEL_WIDTH);
                end
                default:
                begin
                    acc_next = '0;
                    sh_next  = opa << SQ_SH;
                    cnt_next = CNT_W'(STATE_WIDTH);
                end
            endcase
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            case (op_reg)
                OP_MUL:
                begin
                    acc_next = mul_sum;
                    sh_next  = sh_reg << DIGIT_W;
                end
                OP_DIV:
                begin
                    acc_next = rem_next;
                    sh_next  = sh_reg << 1;
                    q_next   = {q_reg[MUL_W-2:0], ge};
                end
                default:
                begin
                    acc_next = rem_next;
                    sh_next  = sh_reg << 2;
                    q_next   = {q_reg[MUL_W-2:0], ge};
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        ovf_reg  <= ovf_next;
        acc_reg  <= acc_next;
        sh_reg   <= sh_next;
        d_reg    <= d_next;
        q_reg    <= q_next;
        mula_reg <= mula_next;
    end

    // Response.
    assign rsp.done = busy_reg && (cnt_reg == '0);
    assign rsp.ovf  = ovf_reg;
    assign result   = (op_reg == OP_MUL) ? acc_reg : WIDE_W'(q_reg);

endmodule

// ===== hdl/orbit_gravity_integrator.sv =====
// Top level of the inverse-square gravity integrator for one body in 2D.
// Depends on ogi_pkg, the channel interfaces in ogi_ifs.sv and ogi_alu.
//
//  channel | dir | word                                          | accepted when
//  --------+-----+-----------------------------------------------+--------------------
//  in_ch   | in  | mode, load_pos_x/y, load_vel_x/y              | valid && ready
//  out_ch  | out | new_pos_x/y, new_vel_x/y, accel_x/y, flags    | valid && ready
//  cfg     | in  | index, data (register write)                  | valid && ready
//
// A step word runs every product, quotient and root through the one shared unit,
// which retires 16 multiplier bits, one quotient bit or one root bit per cycle; at
// the origin the gravity, acceleration and square-root operations are skipped.
// Input is not ready while a word is at work.
// A finished result sits in the output register; input is ready again meanwhile.
// Reset is asynchronous, active low, and restores the register defaults.
module orbit_gravity_integrator import ogi_pkg::*; #(
    parameter int STATE_WIDTH = 40,
    parameter int ACCEL_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    ogi_in_if.sink    in_ch,
    ogi_out_if.source out_ch,
    ogi_cfg_if.sink   cfg
);

    localparam int SW = STATE_WIDTH;
    localparam int AW = ACCEL_WIDTH;
    localparam int WK = WIDE_W + 2;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_MXX  = 5'd1;
    localparam logic [4:0] S_MYY  = 5'd2;
    localparam logic [4:0] S_GR   = 5'd3;
    localparam logic [4:0] S_GRR  = 5'd4;
    localparam logic [4:0] S_GDIV = 5'd5;
    localparam logic [4:0] S_SQRT = 5'd6;
    localparam logic [4:0] S_AXM  = 5'd7;
    localparam logic [4:0] S_AXD  = 5'd8;
    localparam logic [4:0] S_AYM  = 5'd9;
    localparam logic [4:0] S_AYD  = 5'd10;
    localparam logic [4:0] S_DT2  = 5'd11;
    localparam logic [4:0] S_VXM  = 5'd12;
    localparam logic [4:0] S_VYM  = 5'd13;
    localparam logic [4:0] S_PX1  = 5'd14;
    localparam logic [4:0] S_PX2  = 5'd15;
    localparam logic [4:0] S_PY1  = 5'd16;
    localparam logic [4:0] S_PY2  = 5'd17;
    localparam logic [4:0] S_DONE = 5'd18;

    function automatic logic [SW-1:0] mag_state(input logic signed [SW-1:0] v);
        return v[SW-1] ? -v : v;
    endfunction

    function automatic logic [AW-1:0] mag_accel(input logic signed [AW-1:0] v);
        return v[AW-1] ? -v : v;
    endfunction

    function automatic logic signed [WK-1:0] sign_prod(input logic [WIDE_W-1:0] p,
                                                       input logic neg);
        logic signed [WK-1:0] ext;
        ext = {2'b00, p};
        return neg ? -ext : ext;
    endfunction

    // Upper bit flags a clamp; lower bits hold the clamped state value.
    function automatic logic [SW:0] clamp_state(input logic signed [WK-1:0] v);
        logic signed [WK-1:0] hi;
        hi = v >>> (SW - 1);
        if (hi == '0 || hi == '1)
            return {1'b0, v[SW-1:0]};
        else if (v[WK-1])
            return {1'b1, 1'b1, {(SW-1){1'b0}}};
        else
            return {1'b1, 1'b0, {(SW-1){1'b1}}};
    endfunction

    logic [4:0] state_reg, state_next;
    logic       issued_reg, issued_next;

    logic [DT_W-1:0]     dt_reg, dt_next;
    logic [RADIUS_W-1:0] rad_reg, rad_next;
    logic [GRAV_W-1:0]   g0_reg, g0_next;

    logic signed [SW-1:0] pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic signed [SW-1:0] vel_x_reg, vel_x_next, vel_y_reg, vel_y_next;
    logic signed [AW-1:0] ax_reg, ax_next, ay_reg, ay_next;
    logic                 center_reg, center_next, sat_reg, sat_next;

    logic [WIDE_W-1:0]    s_reg, s_next, n_reg, n_next;
    logic [AW-1:0]        g_reg, g_next;
    logic [MUL_W-1:0]     r_reg, r_next;
    logic [2*DT_W-1:0]    dt2_reg, dt2_next;
    logic signed [WK-1:0] t1_reg, t1_next;

    logic                 out_valid_reg, out_valid_next;
    logic signed [SW-1:0] o_px_reg, o_px_next, o_py_reg, o_py_next;
    logic signed [SW-1:0] o_vx_reg, o_vx_next, o_vy_reg, o_vy_next;
    logic signed [AW-1:0] o_ax_reg, o_ax_next, o_ay_reg, o_ay_next;
    logic                 o_center_reg, o_center_next, o_sat_reg, o_sat_next;

    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;
    logic [WIDE_W-1:0] alu_opa, alu_opb, alu_res;

    logic [SW-1:0] mag_px, mag_py, mag_vx, mag_vy;
    logic [AW-1:0] mag_ax, mag_ay;
    logic          stepping;

    assign mag_px = mag_state(pos_x_reg);
    assign mag_py = mag_state(pos_y_reg);
    assign mag_vx = mag_state(vel_x_reg);
    assign mag_vy = mag_state(vel_y_reg);
    assign mag_ax = mag_accel(ax_reg);
    assign mag_ay = mag_accel(ay_reg);

    assign stepping = (state_reg != S_IDLE) && (state_reg != S_DONE);

    // Operand selection for the shared unit.
    always_comb
    begin
        alu_opa = '0;
        alu_opb = '0;
        alu_req.op = OP_MUL;
        case (state_reg)
            S_MXX:  begin alu_opa = WIDE_W'(mag_px); alu_opb = WIDE_W'(mag_px); end
            S_MYY:  begin alu_opa = WIDE_W'(mag_py); alu_opb = WIDE_W'(mag_py); end
            S_GR:
            begin
                alu_opa = WIDE_W'({g0_reg, 8'h00});
                alu_opb = WIDE_W'({rad_reg, 8'h00});
            end
            S_GRR:
            begin
                alu_opa = WIDE_W'(n_reg[MUL_W-1:0]);
                alu_opb = WIDE_W'({rad_reg, 8'h00});
            end
            S_GDIV: begin alu_opa = n_reg; alu_opb = s_reg; alu_req.op = OP_DIV; end
            S_SQRT: begin alu_opa = s_reg; alu_req.op = OP_SQRT; end
            S_AXM:  begin alu_opa = WIDE_W'(g_reg); alu_opb = WIDE_W'(mag_px); end
            S_AXD:  begin alu_opa = n_reg; alu_opb = WIDE_W'(r_reg); alu_req.op = OP_DIV; end
            S_AYM:  begin alu_opa = WIDE_W'(g_reg); alu_opb = WIDE_W'(mag_py); end
            S_AYD:  begin alu_opa = n_reg; alu_opb = WIDE_W'(r_reg); alu_req.op = OP_DIV; end
            S_DT2:  begin alu_opa = WIDE_W'(dt_reg); alu_opb = WIDE_W'(dt_reg); end
            S_VXM:  begin alu_opa = WIDE_W'(mag_ax); alu_opb = WIDE_W'(dt_reg); end
            S_VYM:  begin alu_opa = WIDE_W'(mag_ay); alu_opb = WIDE_W'(dt_reg); end
            S_PX1:  begin alu_opa = WIDE_W'(mag_vx); alu_opb = WIDE_W'({dt_reg, 9'h000}); end
            S_PX2:  begin alu_opa = WIDE_W'(mag_ax); alu_opb = WIDE_W'(dt2_reg); end
            S_PY1:  begin alu_opa = WIDE_W'(mag_vy); alu_opb = WIDE_W'({dt_reg, 9'h000}); end
            S_PY2:  begin alu_opa = WIDE_W'(mag_ay); alu_opb = WIDE_W'(dt2_reg); end
            default: begin alu_opa = '0; alu_opb = '0; end
        endcase
        alu_req.start = stepping && !issued_reg;
    end

    ogi_alu #(
        .STATE_WIDTH (STATE_WIDTH),
        .ACCEL_WIDTH (ACCEL_WIDTH)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .opa    (alu_opa),
        .opb    (alu_opb),
        .rsp    (alu_rsp),
        .result (alu_res)
    );

    // Sequencer, write-back of unit results and output register.
    always_comb
    begin
        logic signed [SW-1:0]  comp;
        logic [AW-1:0]         qmag;
        logic [AW-1:0]         lim;
        logic                  neg_res;
        logic signed [WK-1:0]  sp;
        logic signed [WK-1:0]  sum;
        logic [SW:0]           cl;
        logic [WIDE_W-1:0]     ssum;

        state_next     = state_reg;
        issued_next    = issued_reg;
        dt_next        = dt_reg;
        rad_next       = rad_reg;
        g0_next        = g0_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        vel_x_next     = vel_x_reg;
        vel_y_next     = vel_y_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        center_next    = center_reg;
        sat_next       = sat_reg;
        s_next         = s_reg;
        n_next         = n_reg;
        g_next         = g_reg;
        r_next         = r_reg;
        dt2_next       = dt2_reg;
        t1_next        = t1_reg;
        out_valid_next = out_valid_reg;
        o_px_next      = o_px_reg;
        o_py_next      = o_py_reg;
        o_vx_next      = o_vx_reg;
        o_vy_next      = o_vy_reg;
        o_ax_next      = o_ax_reg;
        o_ay_next      = o_ay_reg;
        o_center_next  = o_center_reg;
        o_sat_next     = o_sat_reg;

        comp    = (state_reg == S_AXD) ? pos_x_reg : pos_y_reg;
        qmag    = alu_res[AW-1:0];
        neg_res = !comp[SW-1] && (comp != '0);
        lim     = neg_res ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
        sp      = '0;
        sum     = '0;
        cl      = '0;
        ssum    = s_reg + alu_res;

        // Configuration writes.
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_TIME_STEP:       dt_next  = cfg.data[DT_W-1:0];
                CFG_PLANET_RADIUS:   rad_next = cfg.data[RADIUS_W-1:0];
                CFG_SURFACE_GRAVITY: g0_next  = cfg.data[GRAV_W-1:0];
                default: ;
            endcase
        end

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (stepping && !issued_reg)
        begin
            issued_next = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    ax_next     = '0;
                    ay_next     = '0;
                    center_next = 1'b0;
                    sat_next    = 1'b0;
                    if (in_ch.mode)
                    begin
                        state_next = S_MXX;
                    end
                    else
                    begin
                        pos_x_next = in_ch.load_pos_x;
                        pos_y_next = in_ch.load_pos_y;
                        vel_x_next = in_ch.load_vel_x;
                        vel_y_next = in_ch.load_vel_y;
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    o_px_next      = pos_x_reg;
                    o_py_next      = pos_y_reg;
                    o_vx_next      = vel_x_reg;
                    o_vy_next      = vel_y_reg;
                    o_ax_next      = ax_reg;
                    o_ay_next      = ay_reg;
                    o_center_next  = center_reg;
                    o_sat_next     = sat_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                if (issued_reg && alu_rsp.done)
                begin
                    issued_next = 1'b0;
                    case (state_reg)
                        S_MXX:
                        begin
                            s_next     = alu_res;
                            state_next = S_MYY;
                        end
                        S_MYY:
                        begin
                            s_next = ssum;
                            // Body at the origin: no gravity, go to the update.
                            if (ssum == '0)
                            begin
                                center_next = 1'b1;
                                state_next  = S_DT2;
                            end
                            else
                            begin
                                state_next = S_GR;
                            end
                        end
                        S_GR:
                        begin
                            n_next     = alu_res;
                            state_next = S_GRR;
                        end
                        S_GRR:
                        begin
                            n_next     = alu_res;
                            state_next = S_GDIV;
                        end
                        S_GDIV:
                        begin
                            if (alu_rsp.ovf)
                            begin
                                g_next   = '1;
                                sat_next = 1'b1;
                            end
                            else
                            begin
                                g_next = alu_res[AW-1:0];
                            end
                            state_next = S_SQRT;
                        end
                        S_SQRT:
                        begin
                            r_next     = alu_res[MUL_W-1:0];
                            state_next = S_AXM;
                        end
                        S_AXM, S_AYM:
                        begin
                            n_next     = alu_res;
                            state_next = (state_reg == S_AXM) ? S_AXD : S_AYD;
                        end
                        S_AXD, S_AYD:
                        begin
                            if (qmag > lim)
                            begin
                                qmag     = lim;
                                sat_next = 1'b1;
                            end
                            if (state_reg == S_AXD)
                            begin
                                ax_next    = neg_res ? -qmag : qmag;
                                state_next = S_AYM;
                            end
                            else
                            begin
                                ay_next    = neg_res ? -qmag : qmag;
                                state_next = S_DT2;
                            end
                        end
                        S_DT2:
                        begin
                            dt2_next   = alu_res[2*DT_W-1:0];
                            state_next = S_VXM;
                        end
                        S_VXM:
                        begin
                            sp  = sign_prod(alu_res, ax_reg[AW-1]);
                            sum = WK'(vel_x_reg) + (sp >>> 8);
                            cl  = clamp_state(sum);
                            vel_x_next = cl[SW-1:0];
                            sat_next   = sat_reg | cl[SW];
                            state_next = S_VYM;
                        end
                        S_VYM:
                        begin
                            sp  = sign_prod(alu_res, ay_reg[AW-1]);
                            sum = WK'(vel_y_reg) + (sp >>> 8);
                            cl  = clamp_state(sum);
                            vel_y_next = cl[SW-1:0];
                            sat_next   = sat_reg | cl[SW];
                            state_next = S_PX1;
                        end
                        S_PX1:
                        begin
                            t1_next    = sign_prod(alu_res, vel_x_reg[SW-1]);
                            state_next = S_PX2;
                        end
                        S_PX2:
                        begin
                            sp  = sign_prod(alu_res, ax_reg[AW-1]);
                            sum = WK'(pos_x_reg) + ((t1_reg + sp) >>> 17);
                            cl  = clamp_state(sum);
                            pos_x_next = cl[SW-1:0];
                            sat_next   = sat_reg | cl[SW];
                            state_next = S_PY1;
                        end
                        S_PY1:
                        begin
                            t1_next    = sign_prod(alu_res, vel_y_reg[SW-1]);
                            state_next = S_PY2;
                        end
                        S_PY2:
                        begin
                            sp  = sign_prod(alu_res, ay_reg[AW-1]);
                            sum = WK'(pos_y_reg) + ((t1_reg + sp) >>> 17);
                            cl  = clamp_state(sum);
                            pos_y_next = cl[SW-1:0];
                            sat_next   = sat_reg | cl[SW];
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
        endcase
    end

    // Control, configuration and body state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            dt_reg        <= DT_RESET;
            rad_reg       <= RADIUS_RESET;
            g0_reg        <= GRAV_RESET;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            vel_x_reg     <= '0;
            vel_y_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            out_valid_reg <= out_valid_next;
            dt_reg        <= dt_next;
            rad_reg       <= rad_next;
            g0_reg        <= g0_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            vel_x_reg     <= vel_x_next;
            vel_y_reg     <= vel_y_next;
        end
    end

    // Working and output payload registers.
    always_ff @(posedge clk)
    begin
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        center_reg   <= center_next;
        sat_reg      <= sat_next;
        s_reg        <= s_next;
        n_reg        <= n_next;
        g_reg        <= g_next;
        r_reg        <= r_next;
        dt2_reg      <= dt2_next;
        t1_reg       <= t1_next;
        o_px_reg     <= o_px_next;
        o_py_reg     <= o_py_next;
        o_vx_reg     <= o_vx_next;
        o_vy_reg     <= o_vy_next;
        o_ax_reg     <= o_ax_next;
        o_ay_reg     <= o_ay_next;
        o_center_reg <= o_center_next;
        o_sat_reg    <= o_sat_next;
    end

    // Channel outputs.
    assign in_ch.ready      = (state_reg == S_IDLE);
    assign cfg.ready        = 1'b1;
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.new_pos_x = o_px_reg;
    assign out_ch.new_pos_y = o_py_reg;
    assign out_ch.new_vel_x = o_vx_reg;
    assign out_ch.new_vel_y = o_vy_reg;
    assign out_ch.accel_x   = o_ax_reg;
    assign out_ch.accel_y   = o_ay_reg;
    assign out_ch.at_center = o_center_reg;
    assign out_ch.saturated = o_sat_reg;

endmodule

// ===== hdl/ogi_checker.sv =====
// Port-level checks of the orbit gravity integrator, bound to the top level.
// Depends only on the top level's channel signals.
module ogi_port_checks #(
    parameter int STATE_WIDTH = 40,
    parameter int ACCEL_WIDTH = 32
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [STATE_WIDTH-1:0] new_pos_x,
    input logic [ACCEL_WIDTH-1:0] accel_x,
    input logic [ACCEL_WIDTH-1:0] accel_y,
    input logic                   at_center
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its new_pos_x value.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(new_pos_x))
        else $error("result changed while stalled");

    // An accepted word closes the input.
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input open while a word is at work");

    // A new result only appears after the block was busy.
    a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without work");

    // At the origin no acceleration is reported.
    a_center_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && at_center |-> accel_x == '0 && accel_y == '0)
        else $error("acceleration at the origin");

endmodule

bind orbit_gravity_integrator ogi_port_checks #(
    .STATE_WIDTH (STATE_WIDTH),
    .ACCEL_WIDTH (ACCEL_WIDTH)
) u_port_checks (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .new_pos_x (out_ch.new_pos_x),
    .accel_x   (out_ch.accel_x),
    .accel_y   (out_ch.accel_y),
    .at_center (out_ch.at_center)
);
